/* rtl/wvds_pkg.sv */
package wvds_pkg;

   localparam int COMP_WIDTH     = 16;
   localparam int ROTATION_STEPS = 16;
   localparam int TABLE_LEN      = 32;
   localparam int FRAC_BITS      = 20;
   localparam int XY_WIDTH       = COMP_WIDTH + FRAC_BITS + 3;
   localparam int ANG_WIDTH      = 40;
   localparam int ROOT_WIDTH     = COMP_WIDTH;
   localparam int SQ_WIDTH       = 2 * COMP_WIDTH;
   localparam int OUT_WIDTH      = 16;

   localparam logic signed [ANG_WIDTH-1:0] NANO_PER_TURN  = 40'sd360000000000;
   localparam logic signed [ANG_WIDTH-1:0] NANO_HALF_TURN = 40'sd180000000000;
   localparam logic signed [ANG_WIDTH-1:0] NANO_HALF_HUND = 40'sd5000000;

   // divide by 1e7: shift by 7, then reciprocal multiply for 78125
   localparam int DIV_SHIFT    = 7;
   localparam int QUO_WIDTH    = 32;
   localparam int MUL_SHIFT    = 48;
   localparam int DIV_ODD      = 78125;
   localparam logic [QUO_WIDTH-1:0] DIV_RECIP =
      QUO_WIDTH'(((64'd1 << MUL_SHIFT) + 64'(DIV_ODD) - 64'd1) / 64'(DIV_ODD));

   localparam logic [OUT_WIDTH-1:0] DIR_WRAP  = 16'd36000;
   localparam logic [OUT_WIDTH-1:0] SPEED_MAX = 16'hFFFF;

   // atan(2^-i) in 1e-9 degree
   localparam logic signed [ANG_WIDTH-1:0] ATAN_NANO [TABLE_LEN] = '{
      40'sd45000000000, 40'sd26565051177, 40'sd14036243468, 40'sd7125016349,
      40'sd3576334375,  40'sd1789910608,  40'sd895173710,   40'sd447614171,
      40'sd223810500,   40'sd111905677,   40'sd55952892,    40'sd27976453,
      40'sd13988227,    40'sd6994114,     40'sd3497057,     40'sd1748528,
      40'sd874264,      40'sd437132,      40'sd218566,      40'sd109283,
      40'sd54642,       40'sd27321,       40'sd13660,       40'sd6830,
      40'sd3415,        40'sd1708,        40'sd854,         40'sd427,
      40'sd213,         40'sd107,         40'sd53,          40'sd27
   };

   typedef struct packed {
      logic signed [COMP_WIDTH-1:0] u_comp;
      logic signed [COMP_WIDTH-1:0] v_comp;
      logic                         u_present;
      logic                         v_present;
   } req_type;

   typedef struct packed {
      logic [OUT_WIDTH-1:0] wind_dir;
      logic                 dir_ok;
      logic [OUT_WIDTH-1:0] wind_speed;
      logic                 speed_ok;
   } rsp_type;

   typedef struct packed {
      logic signed [XY_WIDTH-1:0]  x;
      logic signed [XY_WIDTH-1:0]  y;
      logic signed [ANG_WIDTH-1:0] z;
   } cordic_type;

   typedef struct packed {
      logic [ROOT_WIDTH-1:0] root;
      logic [SQ_WIDTH-1:0]   rem;
      logic                  speed_ok;
      logic                  dir_ok;
   } root_type;

endpackage

/* rtl/wvds_prep.sv */
module wvds_prep (
   input  logic                 clock,
   input  logic                 en,
   input  wvds_pkg::req_type    req,
   output wvds_pkg::cordic_type cord,
   output wvds_pkg::root_type   root
);

   localparam int W  = wvds_pkg::COMP_WIDTH;
   localparam int XW = wvds_pkg::XY_WIDTH;
   localparam int SW = wvds_pkg::SQ_WIDTH;

   wvds_pkg::cordic_type cord_in, cord_ff;
   wvds_pkg::root_type   root_in, root_ff;

   always_comb begin
      logic signed [XW-1:0] u_sc;
      logic signed [XW-1:0] v_sc;
      logic [W-1:0]         au;
      logic [W-1:0]         av;
      logic [SW-1:0]        sq_u;
      logic [SW-1:0]        sq_v;
      logic                 both;
      u_sc = {{(XW-W){req.u_comp[W-1]}}, req.u_comp} <<< wvds_pkg::FRAC_BITS;
      v_sc = {{(XW-W){req.v_comp[W-1]}}, req.v_comp} <<< wvds_pkg::FRAC_BITS;
      // start in the right half plane of (-v, -u)
      if (!req.v_comp[W-1] && (req.v_comp != '0)) begin
         cord_in.x = v_sc;
         cord_in.y = u_sc;
         cord_in.z = wvds_pkg::NANO_HALF_TURN;
      end else begin
         cord_in.x = -v_sc;
         cord_in.y = -u_sc;
         cord_in.z = '0;
      end
      au   = req.u_comp[W-1] ? $unsigned(-req.u_comp) : $unsigned(req.u_comp);
      av   = req.v_comp[W-1] ? $unsigned(-req.v_comp) : $unsigned(req.v_comp);
      sq_u = SW'(au) * SW'(au);
      sq_v = SW'(av) * SW'(av);
      both = req.u_present && req.v_present;
      root_in.root     = '0;
      root_in.rem      = sq_u + sq_v;
      root_in.speed_ok = both;
      root_in.dir_ok   = both && ((req.u_comp != '0) || (req.v_comp != '0));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cord_ff <= cord_in;
         root_ff <= root_in;
      end
   end

   assign cord = cord_ff;
   assign root = root_ff;

endmodule

/* rtl/wvds_cordic_step.sv */
module wvds_cordic_step #(
   parameter int STEP   = 0,
   parameter bit ROTATE = 1'b1
) (
   input  logic                 clock,
   input  logic                 en,
   input  wvds_pkg::cordic_type cord_d,
   output wvds_pkg::cordic_type cord_q
);

   localparam int XW = wvds_pkg::XY_WIDTH;
   localparam int AW = wvds_pkg::ANG_WIDTH;

   wvds_pkg::cordic_type cord_in, cord_ff;

   always_comb begin
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [XW-1:0] xs;
      logic signed [XW-1:0] ys;
      logic signed [AW-1:0] z;
      x  = cord_d.x;
      y  = cord_d.y;
      z  = cord_d.z;
      xs = x >>> STEP;
      ys = y >>> STEP;
      cord_in = cord_d;
      if (ROTATE) begin
         if (!y[XW-1] && (y != '0)) begin
            cord_in.x = x + ys;
            cord_in.y = y - xs;
            cord_in.z = z + wvds_pkg::ATAN_NANO[STEP];
         end else begin
            cord_in.x = x - ys;
            cord_in.y = y + xs;
            cord_in.z = z - wvds_pkg::ATAN_NANO[STEP];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cord_ff <= cord_in;
      end
   end

   assign cord_q = cord_ff;

endmodule

/* rtl/wvds_sqrt_step.sv */
module wvds_sqrt_step #(
   parameter int BIT    = 0,
   parameter bit ACTIVE = 1'b1
) (
   input  logic               clock,
   input  logic               en,
   input  wvds_pkg::root_type root_d,
   output wvds_pkg::root_type root_q
);

   localparam int RW = wvds_pkg::ROOT_WIDTH;
   localparam int SW = wvds_pkg::SQ_WIDTH;
   localparam int TW = SW + 1;

   wvds_pkg::root_type root_in, root_ff;

   always_comb begin
      logic [TW-1:0] trial;
      logic [TW-1:0] rem_ext;
      logic [TW-1:0] diff;
      // (root + 2^b)^2 - root^2 = root * 2^(b+1) + 2^(2b)
      trial   = (TW'(root_d.root) << (BIT + 1)) + (TW'(1) << (2 * BIT));
      rem_ext = TW'(root_d.rem);
      diff    = rem_ext - trial;
      root_in = root_d;
      if (ACTIVE && (rem_ext >= trial)) begin
         root_in.rem  = diff[SW-1:0];
         root_in.root = root_d.root | (RW'(1) << BIT);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         root_ff <= root_in;
      end
   end

   assign root_q = root_ff;

endmodule

/* rtl/wvds_post.sv */
module wvds_post (
   input  logic                 clock,
   input  logic [2:0]           en,
   input  wvds_pkg::cordic_type cord,
   input  wvds_pkg::root_type   root,
   output wvds_pkg::rsp_type    rsp
);

   localparam int AW = wvds_pkg::ANG_WIDTH;
   localparam int RW = wvds_pkg::ROOT_WIDTH;
   localparam int SW = wvds_pkg::SQ_WIDTH;
   localparam int QW = wvds_pkg::QUO_WIDTH;
   localparam int OW = wvds_pkg::OUT_WIDTH;

   logic [QW-1:0]   quo_a_in, quo_a_ff;
   logic [OW-1:0]   spd_a_in, spd_a_ff, spd_b_ff;
   logic            sok_a_ff, dok_a_ff, sok_b_ff, dok_b_ff;
   logic [2*QW-1:0] prod_b_in, prod_b_ff;
   wvds_pkg::rsp_type rsp_in, rsp_ff;

   // stage A: wrap angle, bias for rounding, round speed
   always_comb begin
      logic signed [AW-1:0] ang;
      logic [AW-1:0]        bias;
      logic [RW:0]          rr;
      ang = cord.z;
      if (ang[AW-1]) begin
         ang = ang + wvds_pkg::NANO_PER_TURN;
      end else if (ang >= wvds_pkg::NANO_PER_TURN) begin
         ang = ang - wvds_pkg::NANO_PER_TURN;
      end
      bias     = $unsigned(ang + wvds_pkg::NANO_HALF_HUND);
      quo_a_in = bias[wvds_pkg::DIV_SHIFT +: QW];
      rr       = {1'b0, root.root} + (RW+1)'(root.rem > SW'(root.root));
      spd_a_in = (rr > (RW+1)'(wvds_pkg::SPEED_MAX)) ? wvds_pkg::SPEED_MAX : OW'(rr);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         quo_a_ff <= quo_a_in;
         spd_a_ff <= spd_a_in;
         sok_a_ff <= root.speed_ok;
         dok_a_ff <= root.dir_ok;
      end
   end

   // stage B: reciprocal multiply
   assign prod_b_in = (2*QW)'(quo_a_ff) * (2*QW)'(wvds_pkg::DIV_RECIP);

   always_ff @(posedge clock) begin
      if (en[1]) begin
         prod_b_ff <= prod_b_in;
         spd_b_ff  <= spd_a_ff;
         sok_b_ff  <= sok_a_ff;
         dok_b_ff  <= dok_a_ff;
      end
   end

   // stage C: quotient, full-turn wrap, masking
   always_comb begin
      logic [OW-1:0] quo;
      logic [OW-1:0] dir;
      quo = prod_b_ff[wvds_pkg::MUL_SHIFT +: OW];
      dir = (quo >= wvds_pkg::DIR_WRAP) ? quo - wvds_pkg::DIR_WRAP : quo;
      rsp_in.wind_dir   = dok_b_ff ? dir : '0;
      rsp_in.dir_ok     = dok_b_ff;
      rsp_in.wind_speed = sok_b_ff ? spd_b_ff : '0;
      rsp_in.speed_ok   = sok_b_ff;
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

/* rtl/wind_vector_to_direction_speed.sv */
// channel  dir  payload             handshake
// req      in   wvds_pkg::req_type  req_valid / req_ready
// rsp      out  wvds_pkg::rsp_type  rsp_valid / rsp_ready
//
// One item per cycle sustained while rsp_ready is high. One prep stage, a chain
// of stages doing one CORDIC iteration (first ROTATION_STEPS) and one square-root bit
// (first COMP_WIDTH) each, then three output stages (round, reciprocal multiply, wrap).
// Reset clears the stage valid bits only.
// A stage holds while its successor is full and held; empty stages keep filling,
// so items are taken under an output stall until the pipeline is full.
module wind_vector_to_direction_speed #(
   parameter int ROTATION_STEPS = wvds_pkg::ROTATION_STEPS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  wvds_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output wvds_pkg::rsp_type rsp_data
);

   localparam int RW    = wvds_pkg::ROOT_WIDTH;
   localparam int CORE  = (ROTATION_STEPS > RW) ? ROTATION_STEPS : RW;
   localparam int DEPTH = CORE + 4;

   logic [DEPTH-1:0] vld_in, vld_ff;
   logic [DEPTH:0]   en;

   wvds_pkg::cordic_type cord [CORE+1];
   wvds_pkg::root_type   root [CORE+1];

   assign en[DEPTH] = rsp_ready;

   for (genvar k = 0; k < DEPTH; k++) begin : g_en
      assign en[k] = !vld_ff[k] || en[k+1];
   end

   always_comb begin
      for (int k = 0; k < DEPTH; k++) begin
         if (en[k]) begin
            vld_in[k] = (k == 0) ? req_valid : vld_ff[(k == 0) ? 0 : k-1];
         end else begin
            vld_in[k] = vld_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   wvds_prep u_prep (
      .clock (clock),
      .en    (en[0]),
      .req   (req_data),
      .cord  (cord[0]),
      .root  (root[0])
   );

   for (genvar k = 0; k < CORE; k++) begin : g_core
      wvds_cordic_step #(
         .STEP   (k),
         .ROTATE (k < ROTATION_STEPS)
      ) u_cordic (
         .clock  (clock),
         .en     (en[k+1]),
         .cord_d (cord[k]),
         .cord_q (cord[k+1])
      );

      wvds_sqrt_step #(
         .BIT    ((k < RW) ? RW - 1 - k : 0),
         .ACTIVE (k < RW)
      ) u_sqrt (
         .clock  (clock),
         .en     (en[k+1]),
         .root_d (root[k]),
         .root_q (root[k+1])
      );
   end

   wvds_post u_post (
      .clock (clock),
      .en    (en[CORE+3:CORE+1]),
      .cord  (cord[CORE]),
      .root  (root[CORE]),
      .rsp   (rsp_data)
   );

   assign req_ready = en[0];
   assign rsp_valid = vld_ff[DEPTH-1];

   a_empty_out_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked while output stage is empty");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> vld_ff[0])
      else $error("accepted item not held in first stage");

   a_dir_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.dir_ok |-> rsp_data.wind_dir < wvds_pkg::DIR_WRAP)
      else $error("direction out of range");

   a_dir_speed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.dir_ok |-> rsp_data.speed_ok && (rsp_data.wind_speed != '0))
      else $error("valid direction without nonzero speed");

   a_missing_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.speed_ok |->
         (rsp_data.wind_speed == '0) && (rsp_data.wind_dir == '0) && !rsp_data.dir_ok)
      else $error("missing input item not zeroed");

endmodule

/* sim/tb.sv */
module tb;

   localparam int CORDIC_STEPS = 16;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int DRAIN_CYCLES = 40;
   localparam int PHASE_ITEMS  = 390;
   localparam int REPORT_MAX   = 10;

   localparam longint TURN_NANO      = 64'sd360000000000;
   localparam longint HALF_TURN_NANO = 64'sd180000000000;
   localparam longint HUND_NANO      = 64'sd10000000;

   longint arctan_nano [CORDIC_STEPS] = '{
      64'sd45000000000, 64'sd26565051177, 64'sd14036243468, 64'sd7125016349,
      64'sd3576334375,  64'sd1789910608,  64'sd895173710,   64'sd447614171,
      64'sd223810500,   64'sd111905677,   64'sd55952892,    64'sd27976453,
      64'sd13988227,    64'sd6994114,     64'sd3497057,     64'sd1748528
   };

   typedef struct {
      wvds_pkg::req_type item;
      bit                fixed;
      wvds_pkg::rsp_type want;
   } vector_row_type;

   logic              clock;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   wvds_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   wvds_pkg::rsp_type rsp_data;

   vector_row_type    stim_rows [$];
   wvds_pkg::rsp_type wind_want [$];

   int cycle_count   = 0;
   int error_count   = 0;
   int checked_count = 0;
   int directed_count = 0;
   int random_count  = 0;
   int burst_left    = 0;
   int gap_max       = 0;
   int stall_pct     = 0;
   int stall_max     = 0;
   int stall_run     = 0;

   wind_vector_to_direction_speed dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // direction blown from (vectoring CORDIC) and rounded magnitude
   function automatic wvds_pkg::rsp_type wind_calc(wvds_pkg::req_type item);
      longint  u, v, s, rem, root, bitv, x, y, z, xs, ys, a, d;
      wvds_pkg::rsp_type res;
      res = '0;
      u = longint'($signed(item.u_comp));
      v = longint'($signed(item.v_comp));
      if (item.u_present && item.v_present) begin
         s = u * u + v * v;
         rem = s;
         root = 0;
         bitv = longint'(1) << 62;
         while (bitv > rem) bitv = bitv >> 2;
         while (bitv != 0) begin
            if (rem >= root + bitv) begin
               rem = rem - (root + bitv);
               root = (root >> 1) + bitv;
            end else begin
               root = root >> 1;
            end
            bitv = bitv >> 2;
         end
         if (s - root * root > root) root++;
         if (root > 65535) root = 65535;
         res.wind_speed = 16'(root);
         res.speed_ok = 1'b1;
         if (u != 0 || v != 0) begin
            x = -v * 1048576;
            y = -u * 1048576;
            z = 0;
            if (x < 0) begin
               x = -x;
               y = -y;
               z = HALF_TURN_NANO;
            end
            for (int i = 0; i < CORDIC_STEPS; i++) begin
               xs = x >>> i;
               ys = y >>> i;
               if (y > 0) begin
                  x = x + ys;
                  y = y - xs;
                  z = z + arctan_nano[i];
               end else begin
                  x = x - ys;
                  y = y + xs;
                  z = z - arctan_nano[i];
               end
            end
            a = z;
            if (a < 0) a = a + TURN_NANO;
            if (a >= TURN_NANO) a = a - TURN_NANO;
            d = (a + HUND_NANO / 2) / HUND_NANO;
            if (d >= 36000) d = d - 36000;
            res.wind_dir = 16'(d);
            res.dir_ok = 1'b1;
         end
      end
      return res;
   endfunction

   function automatic int extreme_comp();
      case ($urandom_range(0, 6))
         0: return -32768;
         1: return -32767;
         2: return -1;
         3: return 0;
         4: return 1;
         5: return 32766;
         default: return 32767;
      endcase
   endfunction

   function automatic wvds_pkg::req_type random_vector();
      wvds_pkg::req_type item;
      int      kind;
      int      u;
      int      v;
      item = '0;
      kind = $urandom_range(0, 99);
      u = $urandom_range(0, 65535) - 32768;
      v = $urandom_range(0, 65535) - 32768;
      item.u_present = 1'b1;
      item.v_present = 1'b1;
      if (kind < 6) begin
         item.u_present = 1'($urandom_range(0, 1));
         item.v_present = item.u_present ? 1'b0 : 1'($urandom_range(0, 1));
      end else if (kind < 10) begin
         u = 0;
         v = 0;
      end else if (kind < 22) begin
         u = $urandom_range(0, 16) - 8;
         v = $urandom_range(0, 16) - 8;
      end else if (kind < 34) begin
         u = extreme_comp();
         v = extreme_comp();
      end else if (kind < 42) begin
         case ($urandom_range(0, 3))
            0: u = 0;
            1: v = 0;
            2: v = u;
            default: v = -u;
         endcase
      end
      item.u_comp = 16'(u);
      item.v_comp = 16'(v);
      return item;
   endfunction

   task automatic add_row(input int u, input int v, input bit up, input bit vp,
                          input bit fixed, input int dir, input bit dok,
                          input int spd, input bit sok);
      vector_row_type row;
      row.item.u_comp    = 16'(u);
      row.item.v_comp    = 16'(v);
      row.item.u_present = up;
      row.item.v_present = vp;
      row.fixed           = fixed;
      row.want.wind_dir   = 16'(dir);
      row.want.dir_ok     = dok;
      row.want.wind_speed = 16'(spd);
      row.want.speed_ok   = sok;
      stim_rows.push_back(row);
   endtask

   task automatic send_item(input wvds_pkg::req_type item, input bit fixed,
                            input wvds_pkg::rsp_type want);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 32);
         gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      wind_want.push_back(fixed ? want : wind_calc(item));
      burst_left--;
   endtask

   always @(posedge clock) begin
      if (stall_run > 0) begin
         stall_run <= stall_run - 1;
         rsp_ready <= 1'b0;
      end else if (!reset && $urandom_range(0, 99) < stall_pct) begin
         stall_run <= $urandom_range(0, stall_max);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      wvds_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (wind_want.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_MAX)
               $display("tb: unexpected result dir=%0d dok=%0d spd=%0d sok=%0d",
                        rsp_data.wind_dir, rsp_data.dir_ok,
                        rsp_data.wind_speed, rsp_data.speed_ok);
         end else begin
            want = wind_want.pop_front();
            checked_count++;
            if (rsp_data.wind_dir !== want.wind_dir || rsp_data.dir_ok !== want.dir_ok ||
                rsp_data.wind_speed !== want.wind_speed ||
                rsp_data.speed_ok !== want.speed_ok) begin
               error_count++;
               if (error_count <= REPORT_MAX) begin
                  $write("tb: mismatch on item %0d: want dir=%0d dok=%0d spd=%0d sok=%0d,",
                         checked_count, want.wind_dir, want.dir_ok, want.wind_speed,
                         want.speed_ok);
                  $display(" got dir=%0d dok=%0d spd=%0d sok=%0d",
                           rsp_data.wind_dir, rsp_data.dir_ok,
                           rsp_data.wind_speed, rsp_data.speed_ok);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      wvds_pkg::req_type item;
      wvds_pkg::rsp_type none;
      none = '0;

      // missing components, zero vector and one plain vector
      add_row(  1234,   -567, 0, 0, 1, 0, 0, 0, 0);
      add_row(-32768,  32767, 0, 1, 1, 0, 0, 0, 0);
      add_row( 32767, -32768, 1, 0, 1, 0, 0, 0, 0);
      add_row(     0,      0, 1, 1, 1, 0, 0, 0, 1);
      add_row(     0,      0, 0, 1, 1, 0, 0, 0, 0);
      add_row(     3,      4, 1, 1, 1, 0, 0, 0, 0);
      stim_rows[$].fixed = 0;
      // full scale corners
      add_row(-32768, -32768, 1, 1, 0, 0, 0, 0, 0);
      add_row( 32767,  32767, 1, 1, 0, 0, 0, 0, 0);
      add_row(-32768,  32767, 1, 1, 0, 0, 0, 0, 0);
      add_row( 32767, -32768, 1, 1, 0, 0, 0, 0, 0);
      // axes; due north input wraps near a full turn
      add_row(     0,   -100, 1, 1, 0, 0, 0, 0, 0);
      add_row(     0,    100, 1, 1, 0, 0, 0, 0, 0);
      add_row(   100,      0, 1, 1, 0, 0, 0, 0, 0);
      add_row(  -100,      0, 1, 1, 0, 0, 0, 0, 0);
      add_row(     1,      0, 1, 1, 0, 0, 0, 0, 0);
      add_row(     0,      1, 1, 1, 0, 0, 0, 0, 0);
      add_row(    -1,     -1, 1, 1, 0, 0, 0, 0, 0);
      add_row(-32768,      0, 1, 1, 0, 0, 0, 0, 0);
      add_row(     0, -32768, 1, 1, 0, 0, 0, 0, 0);
      add_row( 32767,      0, 1, 1, 0, 0, 0, 0, 0);
      add_row(     0,     -1, 1, 1, 0, 0, 0, 0, 0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      gap_max = 3;
      stall_pct = 15;
      stall_max = 4;
      foreach (stim_rows[i]) begin
         send_item(stim_rows[i].item, stim_rows[i].fixed, stim_rows[i].want);
         directed_count++;
      end

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin gap_max = 0;  stall_pct = 0;  stall_max = 0;  end
            1: begin gap_max = 4;  stall_pct = 20; stall_max = 6;  end
            2: begin gap_max = 2;  stall_pct = 60; stall_max = 12; end
            default: begin gap_max = 10; stall_pct = 10; stall_max = 3; end
         endcase
         repeat (PHASE_ITEMS) begin
            item = random_vector();
            send_item(item, 1'b0, none);
            random_count++;
         end
      end
      req_valid <= 1'b0;

      while (wind_want.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (wind_want.size() != 0) error_count++;

      $display("tb: %0d directed and %0d random vectors sent, %0d results checked",
               directed_count, random_count, checked_count);
      $display("tb: missing flags, zero vectors, axes and full-scale corners, with stalls");
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: %0d errors", error_count);
         $display("tb: failure");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/wvds_pkg.sv
rtl/wvds_prep.sv
rtl/wvds_cordic_step.sv
rtl/wvds_sqrt_step.sv
rtl/wvds_post.sv
rtl/wind_vector_to_direction_speed.sv
sim/tb.sv
